// ===== src/rita_pkg.sv =====
// Shared types, constants and helpers for the radix integer-to-ASCII converter.
package rita_pkg;

    localparam logic [6:0] CHAR_ZERO    = 7'd48;
    localparam logic [6:0] CHAR_UPPER_A = 7'd65;
    localparam logic [6:0] CHAR_LOWER_A = 7'd97;
    localparam logic [3:0] DIGIT_TEN    = 4'd10;
    localparam logic [4:0] RADIX_MIN    = 5'd2;
    localparam logic [4:0] RADIX_MAX    = 5'd16;

    // Dividend bits retired per cycle by the long-division chain.
    localparam int DIV_BITS_PER_CYCLE = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_SHOW
    } back_state_t;

    // Classification of one word, produced by the front end.
    typedef struct packed {
        logic [4:0] radix;
        logic       pow2;
        logic [2:0] shift;
        logic       upper;
    } rita_class_t;

    function automatic logic [6:0] ascii_of(input logic [3:0] digit, input logic upper);
        logic [6:0] base;
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (digit >= DIGIT_TEN) begin
            return base + {3'd0, digit} - {3'd0, DIGIT_TEN};
        end
        return CHAR_ZERO + {3'd0, digit};
    endfunction

endpackage

// ===== src/radix_integer_to_ascii.sv =====
// Top level of the radix integer-to-ASCII converter.
//
// Input words (s_value, s_radix, s_uppercase) arrive on a valid/ready channel.
// The radix is clamped into 2..16. Each word produces its digits, most
// significant first, on the m_ channel, one ASCII character per digit, with
// m_last_digit high on the final one. A zero value gives a single '0'.
// A two-entry queue sits behind the front end, so up to two words are taken
// while the engine is still busy or the receiver stalls.
// Per word the engine loads the value, then produces one digit at a time:
// radix 2, 4, 8 or 16 peel each digit with a shift, other radices run the
// long-division chain that retires 8 bits per cycle over the whole value.
// Each character is then read from the digit buffer and held on the
// output until the receiver takes it with m_ready high.
// Worst case for a 64-bit value: 41 digits in base 3, 64 digits in base 2.
// A stalled receiver simply holds the current character; nothing is lost.
// Reset (aresetn low, synchronous) empties the queue and aborts any word
// in progress.
module radix_integer_to_ascii
    import rita_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_value,
    input  logic [4:0]  s_radix,
    input  logic        s_uppercase,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_digit_char,
    output logic        m_last_digit
);

    localparam int CLS_W  = $bits(rita_class_t);
    localparam int DATA_W = VALUE_WIDTH + CLS_W;

    logic                   push_valid;
    logic                   push_ready;
    logic [VALUE_WIDTH-1:0] push_value;
    rita_class_t            push_class;
    logic                   q_valid;
    logic                   q_ready;
    logic [DATA_W-1:0]      q_data;
    rita_class_t            q_class;

    rita_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .s_radix    (s_radix),
        .s_uppercase(s_uppercase),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_value (push_value),
        .push_class (push_class)
    );

    rita_queue #(
        .DATA_W(DATA_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (push_valid),
        .in_ready (push_ready),
        .in_data  ({push_value, push_class}),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_data (q_data)
    );

    assign q_class = rita_class_t'(q_data[CLS_W-1:0]);

    rita_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_value     (q_data[DATA_W-1:CLS_W]),
        .q_class     (q_class),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_digit_char(m_digit_char),
        .m_last_digit(m_last_digit)
    );

endmodule

// ===== src/rita_front.sv =====
// Front end: takes input words, clamps the radix and classifies it for the back end.
module rita_front
    import rita_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [63:0]            s_value,
    input  logic [4:0]             s_radix,
    input  logic                   s_uppercase,
    output logic                   push_valid,
    input  logic                   push_ready,
    output logic [VALUE_WIDTH-1:0] push_value,
    output rita_class_t            push_class
);

    logic [4:0] radix_clamped;

    always_comb begin
        priority if (s_radix < RADIX_MIN) begin
            radix_clamped = RADIX_MIN;
        end else if (s_radix > RADIX_MAX) begin
            radix_clamped = RADIX_MAX;
        end else begin
            radix_clamped = s_radix;
        end
    end

    // Power-of-two radices skip the divider and peel digits with a shift.
    always_comb begin
        push_class.radix = radix_clamped;
        push_class.upper = s_uppercase;
        unique case (radix_clamped)
            5'd2: begin
                push_class.pow2  = 1'b1;
                push_class.shift = 3'd1;
            end
            5'd4: begin
                push_class.pow2  = 1'b1;
                push_class.shift = 3'd2;
            end
            5'd8: begin
                push_class.pow2  = 1'b1;
                push_class.shift = 3'd3;
            end
            5'd16: begin
                push_class.pow2  = 1'b1;
                push_class.shift = 3'd4;
            end
            default: begin
                push_class.pow2  = 1'b0;
                push_class.shift = 3'd0;
            end
        endcase
    end

    assign push_value = s_value[VALUE_WIDTH-1:0];
    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

// ===== src/rita_queue.sv =====
// Two-entry queue between the front end and the conversion engine.
module rita_queue
    import rita_pkg::*;
#(
    parameter int DATA_W = 74
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== src/rita_back.sv =====
// Conversion engine: divides out the digits into a buffer, then sends them most significant first.
module rita_back
    import rita_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  logic [VALUE_WIDTH-1:0] q_value,
    input  rita_class_t            q_class,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [6:0]             m_digit_char,
    output logic                   m_last_digit
);

    localparam int NUM_STEPS = (VALUE_WIDTH + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
    localparam int DIV_W     = NUM_STEPS * DIV_BITS_PER_CYCLE;
    localparam int STEP_W    = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
    localparam int ADDR_W    = $clog2(VALUE_WIDTH);
    localparam int CNT_W     = $clog2(VALUE_WIDTH + 1);

    back_state_t       state_reg;
    back_state_t       state_next;
    rita_class_t       cls_reg;
    logic [DIV_W-1:0]  quot_reg;
    logic [3:0]        rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [3:0]        rd_data_reg;
    logic [3:0]        digit_mem [VALUE_WIDTH];

    logic [DIV_W-1:0]  div_quot;
    logic [3:0]        div_rem;
    logic [DIV_W-1:0]  pw_quot;
    logic [3:0]        pw_digit;
    logic [DIV_W-1:0]  new_quot;
    logic [3:0]        new_digit;
    logic              digit_done;
    logic              quot_zero;

    // Restoring division, several dividend bits per cycle. The partial
    // remainder stays below the radix, so it fits in four bits.
    always_comb begin
        logic [3:0]       r;
        logic [4:0]       t;
        logic [DIV_W-1:0] w;
        r = rem_reg;
        w = quot_reg;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
            t = {r, w[DIV_W-1]};
            w = {w[DIV_W-2:0], 1'b0};
            if (t >= cls_reg.radix) begin
                t    = t - cls_reg.radix;
                r    = t[3:0];
                w[0] = 1'b1;
            end else begin
                r = t[3:0];
            end
        end
        div_quot = w;
        div_rem  = r;
    end

    assign pw_quot    = quot_reg >> cls_reg.shift;
    assign pw_digit   = quot_reg[3:0] & (cls_reg.radix[3:0] - 4'd1);
    assign new_quot   = cls_reg.pow2 ? pw_quot : div_quot;
    assign new_digit  = cls_reg.pow2 ? pw_digit : div_rem;
    assign digit_done = (state_reg == ST_DIV)
                        && (cls_reg.pow2 || (step_reg == STEP_W'(NUM_STEPS - 1)));
    assign quot_zero  = (new_quot == '0);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (digit_done && quot_zero) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_SHOW;
            end
            ST_SHOW: begin
                if (m_ready) begin
                    state_next = (idx_reg == '0) ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        q_ready      = (state_reg == ST_IDLE);
        m_valid      = (state_reg == ST_SHOW);
        m_last_digit = (idx_reg == '0);
        m_digit_char = ascii_of(rd_data_reg, cls_reg.upper);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        step_reg <= '0;
                        cnt_reg  <= '0;
                    end
                end
                ST_DIV: begin
                    if (digit_done) begin
                        step_reg <= '0;
                        cnt_reg  <= cnt_reg + CNT_W'(1);
                        if (quot_zero) begin
                            idx_reg <= cnt_reg[ADDR_W-1:0];
                        end
                    end else begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_SHOW: begin
                    if (m_ready && (idx_reg != '0)) begin
                        idx_reg <= idx_reg - ADDR_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && q_valid) begin
            quot_reg <= DIV_W'(q_value);
            cls_reg  <= q_class;
            rem_reg  <= 4'd0;
        end else if (state_reg == ST_DIV) begin
            if (digit_done) begin
                quot_reg <= new_quot;
                rem_reg  <= 4'd0;
            end else begin
                quot_reg <= div_quot;
                rem_reg  <= div_rem;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (digit_done) begin
            digit_mem[cnt_reg[ADDR_W-1:0]] <= new_digit;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= digit_mem[idx_reg];
    end

endmodule
